FILE: sv/gscan_pkg.sv
// Shared types for the Graham scan convex hull core.
`timescale 1ns / 1ps
package gscan_pkg;
  typedef enum logic [4:0] {
    ST_LOAD,
    ST_PIV_RD,
    ST_PIV_CMP,
    ST_SORT_INIT,
    ST_SORT_RDA,
    ST_SORT_RDB,
    ST_SORT_CMP,
    ST_SORT_LDB,
    ST_SORT_DIST,
    ST_SORT_DEC,
    ST_SCAN_INIT,
    ST_SCAN_RD,
    ST_SCAN_RDA,
    ST_SCAN_RDB,
    ST_SCAN_RDC,
    ST_SCAN_RDP,
    ST_SCAN_MUL,
    ST_SCAN_CMP,
    ST_SCAN_PUSH,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_LD,
    ST_EMIT
  } gs_state_t;
endpackage

FILE: sv/graham_scan_convex_hull_core.sv
// Graham scan convex hull core: point store, insertion sort and stack scan.
`timescale 1ns / 1ps
// A point not marked last is taken every cycle, back to back. A last point starts a pivot
// search, an insertion sort and a stack scan, then the hull vertices are sent out; a set of
// fewer than three points goes straight to output. The sort and the scan share one compare
// unit and the single point-store read port. One set is processed at a time; in_ready is
// low from the last point until the final vertex is taken. Synchronous active-low reset
// clears the sequencer, the load count and the stack depth only.
module graham_scan_convex_hull_core
  import gscan_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic                         in_last_point,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_vertex_x,
  output logic signed [COORD_BITS-1:0] out_vertex_y,
  output logic                         out_last_vertex
);
  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // memories
  coord_t        px_mem [MAX_POINTS];
  coord_t        py_mem [MAX_POINTS];
  logic [IW-1:0] ord_mem [MAX_POINTS];
  logic [IW-1:0] stk_mem [MAX_POINTS];

  gs_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] sd_r, sd_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] oth_r, oth_nxt;
  coord_t pvx_r, pvx_nxt, pvy_r, pvy_nxt;
  coord_t ax_r, ax_nxt, ay_r, ay_nxt;
  coord_t bx_r, bx_nxt, by_r, by_nxt;
  coord_t rx_r, ry_r;
  logic last_r, last_nxt;

  // point store read port
  logic [IW-1:0] prd_addr;
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && cnt_r < CW'(MAX_POINTS)) begin
      px_mem[cnt_r[IW-1:0]] <= in_point_x;
      py_mem[cnt_r[IW-1:0]] <= in_point_y;
    end
    rx_r <= px_mem[prd_addr];
    ry_r <= py_mem[prd_addr];
  end

  // order and stack memories
  logic          ord_we, stk_we;
  logic [IW-1:0] ord_wa, ord_wd, ord_ra, stk_wa, stk_wd, stk_ra;
  logic [IW-1:0] ord_q, stk_q;
  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    ord_q <= ord_mem[ord_ra];
    stk_q <= stk_mem[stk_ra];
  end

  // shared compare unit: cross sign of (a - p) x (b - p) and squared distances
  logic signed [DW-1:0] dax, day, dbx, dby;
  logic signed [PW-1:0] p1, p2;
  logic                 cr_pos, cr_zero;
  always_comb begin
    dax = DW'(ax_r) - DW'(pvx_r);
    day = DW'(ay_r) - DW'(pvy_r);
    dbx = DW'(bx_r) - DW'(pvx_r);
    dby = DW'(by_r) - DW'(pvy_r);
    p1  = PW'(dax * dby);
    p2  = PW'(day * dbx);
  end
  logic signed [PW-1:0] p1_r, p2_r;
  logic signed [PW:0]   d1_r, d2_r;
  always_ff @(posedge clk) begin
    p1_r <= p1;
    p2_r <= p2;
    d1_r <= (PW+1)'(dax * dax) + (PW+1)'(day * day);
    d2_r <= (PW+1)'(dbx * dbx) + (PW+1)'(dby * dby);
  end
  assign cr_pos  = p1_r > p2_r;
  assign cr_zero = p1_r == p2_r;

  logic a_piv, b_piv;
  assign a_piv = (ax_r == pvx_r) && (ay_r == pvy_r);
  assign b_piv = (bx_r == pvx_r) && (by_r == pvy_r);

  // a sorts ahead of b; in the scan, p = second, a = new, b = top: left turn when p2 > p1
  logic sort_ahead, left_turn;
  assign sort_ahead = (a_piv || b_piv) ? (a_piv && !b_piv) :
                      (cr_zero ? (d1_r < d2_r) : cr_pos);
  assign left_turn  = p2_r > p1_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      sd_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sd_r    <= sd_nxt;
    end
  end
  always_ff @(posedge clk) begin
    n_r <= n_nxt; i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
    cur_r <= cur_nxt; oth_r <= oth_nxt;
    pvx_r <= pvx_nxt; pvy_r <= pvy_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; bx_r <= bx_nxt; by_r <= by_nxt;
    last_r <= last_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; n_nxt = n_r; i_nxt = i_r; j_nxt = j_r; sd_nxt = sd_r; k_nxt = k_r;
    cur_nxt = cur_r; oth_nxt = oth_r;
    pvx_nxt = pvx_r; pvy_nxt = pvy_r;
    ax_nxt = ax_r; ay_nxt = ay_r; bx_nxt = bx_r; by_nxt = by_r;
    last_nxt = last_r;
    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CW'(MAX_POINTS)) cnt_nxt = cnt_r + CW'(1);
          if (in_last_point) begin
            n_nxt   = (cnt_r < CW'(MAX_POINTS)) ? cnt_r + CW'(1) : cnt_r;
            cnt_nxt = '0;
            i_nxt   = '0;
            if (n_nxt == '0) state_nxt = ST_LOAD;
            else if (n_nxt < CW'(3)) begin
              sd_nxt = n_nxt; state_nxt = ST_EMIT_RD; k_nxt = '0;
            end else state_nxt = ST_PIV_RD;
          end
        end
      end
      ST_PIV_RD: state_nxt = ST_PIV_CMP;
      ST_PIV_CMP: begin
        // keep lowest y, then lowest x, first stored wins
        if (i_r == '0 || ry_r < pvy_r || (ry_r == pvy_r && rx_r < pvx_r)) begin
          pvx_nxt = rx_r; pvy_nxt = ry_r;
        end
        if (i_r + CW'(1) == n_r) begin
          i_nxt = '0; state_nxt = ST_SORT_INIT;
        end else begin
          i_nxt = i_r + CW'(1); state_nxt = ST_PIV_RD;
        end
      end
      ST_SORT_INIT: begin
        cur_nxt = i_r[IW-1:0];
        j_nxt = i_r;
        state_nxt = (i_r == '0) ? ST_SORT_DEC : ST_SORT_RDA;
      end
      ST_SORT_RDA: begin
        ax_nxt = rx_r; ay_nxt = ry_r; state_nxt = ST_SORT_RDB;
      end
      ST_SORT_RDB: state_nxt = ST_SORT_CMP;
      ST_SORT_CMP: begin
        oth_nxt = ord_q; state_nxt = ST_SORT_LDB;
      end
      ST_SORT_LDB: begin
        bx_nxt = rx_r; by_nxt = ry_r; state_nxt = ST_SORT_DIST;
      end
      ST_SORT_DIST: state_nxt = ST_SORT_DEC;
      ST_SORT_DEC: begin
        // j == 0 or compare fails: drop cur at slot j
        if (j_r == '0 || !sort_ahead) begin
          if (i_r + CW'(1) == n_r) state_nxt = ST_SCAN_INIT;
          else state_nxt = ST_SORT_INIT;
          i_nxt = i_r + CW'(1);
        end else begin
          j_nxt = j_r - CW'(1);
          state_nxt = (j_r == CW'(1)) ? ST_SORT_DEC : ST_SORT_RDB;
        end
      end
      ST_SCAN_INIT: begin
        k_nxt = '0; sd_nxt = '0; i_nxt = '0; state_nxt = ST_SCAN_RD;
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_RDA;
      ST_SCAN_RDA: begin
        cur_nxt = ord_q;
        if (sd_r < CW'(2)) state_nxt = ST_SCAN_PUSH;
        else state_nxt = ST_SCAN_RDB;
      end
      // load new point into a, top into b, then second-from-top into the pivot regs
      ST_SCAN_RDB: begin
        ax_nxt = rx_r; ay_nxt = ry_r; state_nxt = ST_SCAN_RDC;
      end
      ST_SCAN_RDC: begin
        bx_nxt = rx_r; by_nxt = ry_r; state_nxt = ST_SCAN_RDP;
      end
      ST_SCAN_RDP: begin
        pvx_nxt = rx_r; pvy_nxt = ry_r; state_nxt = ST_SCAN_MUL;
      end
      ST_SCAN_MUL: state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        // pop the top unless it makes a strict left turn
        if (!left_turn) begin
          sd_nxt = sd_r - CW'(1);
          state_nxt = (sd_r - CW'(1) < CW'(2)) ? ST_SCAN_PUSH : ST_SCAN_RDB;
        end else state_nxt = ST_SCAN_PUSH;
      end
      ST_SCAN_PUSH: begin
        sd_nxt = sd_r + CW'(1);
        if (i_r + CW'(1) == n_r) begin
          k_nxt = '0; state_nxt = ST_EMIT_RD;
        end else begin
          i_nxt = i_r + CW'(1); state_nxt = ST_SCAN_RD;
        end
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_WAIT;
      ST_EMIT_WAIT: state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: begin
        ax_nxt = rx_r; ay_nxt = ry_r; last_nxt = (k_r + CW'(1) == sd_r);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          k_nxt = k_r + CW'(1);
          if (last_r) begin
            sd_nxt = '0; state_nxt = ST_LOAD;
          end else state_nxt = ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // memory addressing and outputs
  logic small_set;
  assign small_set = (n_r < CW'(3));
  always_comb begin
    in_ready = (state_r == ST_LOAD);
    out_valid = (state_r == ST_EMIT);
    out_vertex_x = ax_r;
    out_vertex_y = ay_r;
    out_last_vertex = last_r;
    prd_addr = i_r[IW-1:0];
    ord_we = 1'b0; ord_wa = j_r[IW-1:0]; ord_wd = cur_r; ord_ra = '0;
    stk_we = 1'b0; stk_wa = sd_r[IW-1:0]; stk_wd = cur_r; stk_ra = '0;
    case (state_r)
      ST_SORT_INIT: prd_addr = i_r[IW-1:0];
      ST_SORT_RDB: ord_ra = j_r[IW-1:0] - 1'b1;
      ST_SORT_CMP: prd_addr = ord_q;
      ST_SORT_DEC: begin
        ord_we = 1'b1;
        if (j_r == '0 || !sort_ahead) ord_wd = cur_r;
        else ord_wd = oth_r;
      end
      ST_SCAN_RD: ord_ra = i_r[IW-1:0];
      ST_SCAN_RDA: begin
        prd_addr = ord_q; stk_ra = sd_r[IW-1:0] - 1'b1;
      end
      ST_SCAN_RDB: begin
        prd_addr = stk_q; stk_ra = sd_r[IW-1:0] - 2'd2;
      end
      ST_SCAN_RDC: prd_addr = stk_q;
      ST_SCAN_CMP: begin
        prd_addr = cur_r; stk_ra = sd_r[IW-1:0] - 2'd2;
      end
      ST_SCAN_PUSH: stk_we = 1'b1;
      ST_EMIT_RD: stk_ra = k_r[IW-1:0];
      ST_EMIT_WAIT: prd_addr = small_set ? k_r[IW-1:0] : stk_q;
      default: ;
    endcase
  end
endmodule
